[sv/dge_pkg.sv]
// Shared types and constants for the dual-gradient energy block.
package dge_pkg;

    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 128;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [7:0] SIZE_RESET = 8'd128;

    localparam int PIX_W = 24;
    localparam int SUM_W = 20;
    localparam int ROOT_W = 10;
    localparam int SQRT_STAGES = 5;

    // floor(x/10) == (x*205) >> 11 for x < 1029
    localparam logic [10:0] DIV10_MULT  = 11'd205;
    localparam int          DIV10_SHIFT = 11;

    typedef struct packed {
        logic       opcode;
        logic [6:0] row;
        logic [6:0] col;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } req_t;

    typedef struct packed {
        logic [5:0] energy;
        logic       out_of_range;
    } rsp_t;

endpackage

[sv/dge_ram.sv]
// Generic single-port RAM with registered read.
module dge_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[addr] <= wdata;
            else
                rdata <= mem[addr];
        end
    end

endmodule

[sv/dual_gradient_energy_top.sv]
// Dual-gradient energy: frame store, neighbor read sequencer and energy pipeline.
// An in-frame query makes four neighbor reads on the single-port frame memory; no
// new request is taken until its last read is issued. Loads and out-of-frame queries
// do not hold the request port. A query passes the reads, difference, square, sum,
// 5 root stages, divide and output registers; an out-of-frame one skips the reads.
// Reset clears control state and sets both size registers to 128; the frame
// memory is not cleared and must be loaded before it is queried.
module dual_gradient_energy_top #(
    parameter int MAX_WIDTH  = dge_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = dge_pkg::DEF_MAX_HEIGHT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  dge_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output dge_pkg::rsp_t rsp,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import dge_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RAM_DEPTH = (DEPTH > 1) ? DEPTH : 2;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LAST = 2'd3;

    // configuration
    logic [7:0] width_reg, height_reg;
    logic       cfg_wr;
    logic [7:0] eff_w, eff_h;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIZE_RESET;
            height_reg <= SIZE_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[7:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_IMAGE_WIDTH:  prdata = {24'd0, width_reg};
            REG_IMAGE_HEIGHT: prdata = {24'd0, height_reg};
            default:          prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        if (width_reg == 8'd0)
            eff_w = 8'd1;
        else if (32'(width_reg) > MAX_WIDTH)
            eff_w = 8'(MAX_WIDTH);
        else
            eff_w = width_reg;
        if (height_reg == 8'd0)
            eff_h = 8'd1;
        else if (32'(height_reg) > MAX_HEIGHT)
            eff_h = 8'(MAX_HEIGHT);
        else
            eff_h = height_reg;
    end

    function automatic logic [AW-1:0] pix_addr(input logic [7:0] r, input logic [7:0] c);
        return AW'(AW'(r) * AW'(MAX_WIDTH)) + AW'(c);
    endfunction

    // pipeline advance: stops only when the output skid slot is occupied
    logic adv;
    logic skid_valid_reg;
    assign adv = !skid_valid_reg;

    // request decode
    logic       accept, in_frame, is_query;
    logic [7:0] r8, c8, cr, cl, rd, ru;

    assign r8       = {1'b0, req.row};
    assign c8       = {1'b0, req.col};
    assign in_frame = (r8 < eff_h) && (c8 < eff_w);
    assign is_query = (req.opcode == OP_QUERY);

    assign cr = (c8 + 8'd1 == eff_w) ? 8'd0 : c8 + 8'd1;
    assign cl = (c8 == 8'd0) ? eff_w - 8'd1 : c8 - 8'd1;
    assign rd = (r8 + 8'd1 == eff_h) ? 8'd0 : r8 + 8'd1;
    assign ru = (r8 == 8'd0) ? eff_h - 8'd1 : r8 - 8'd1;

    // read sequencer
    logic [1:0]    phase_reg, phase_next;
    logic [AW-1:0] addr_reg [1:3];

    assign req_ready = adv && (phase_reg == PH_IDLE);
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        phase_next = phase_reg;
        if (adv)
        begin
            if (phase_reg != PH_IDLE)
                phase_next = (phase_reg == PH_LAST) ? PH_IDLE : phase_reg + 2'd1;
            else if (accept && is_query && in_frame)
                phase_next = 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= PH_IDLE;
        else
            phase_reg <= phase_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg[1] <= pix_addr(r8, cl);
            addr_reg[2] <= pix_addr(rd, c8);
            addr_reg[3] <= pix_addr(ru, c8);
        end
    end

    // frame memory
    logic             ram_en, ram_we;
    logic [AW-1:0]    ram_addr;
    logic [PIX_W-1:0] ram_rdata;

    always_comb
    begin
        ram_en   = 1'b0;
        ram_we   = 1'b0;
        ram_addr = pix_addr(r8, cr);
        if (adv && phase_reg != PH_IDLE)
        begin
            ram_en   = 1'b1;
            ram_addr = addr_reg[phase_reg];
        end
        else if (accept && in_frame)
        begin
            ram_en = 1'b1;
            ram_we = !is_query;
            ram_addr = is_query ? pix_addr(r8, cr) : pix_addr(r8, c8);
        end
    end

    dge_ram #(
        .WIDTH (PIX_W),
        .DEPTH (RAM_DEPTH)
    ) u_frame (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata ({req.red, req.green, req.blue}),
        .rdata (ram_rdata)
    );

    // read issue tracking
    logic       iss_valid_reg, iss_oor_reg;
    logic [1:0] iss_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            iss_valid_reg <= 1'b0;
        else if (adv)
            iss_valid_reg <= (phase_reg != PH_IDLE) || (accept && is_query);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            iss_idx_reg <= phase_reg;
            iss_oor_reg <= (phase_reg == PH_IDLE) && !in_frame;
        end
    end

    // gather right, left, down; up arrives with the last read
    logic [PIX_W-1:0] pix_reg [0:2];
    logic             iss_done;

    assign iss_done = iss_valid_reg && (iss_oor_reg || iss_idx_reg == PH_LAST);

    always_ff @(posedge clk)
    begin
        if (adv && iss_valid_reg && !iss_oor_reg && iss_idx_reg != PH_LAST)
            pix_reg[iss_idx_reg] <= ram_rdata;
    end

    // stage: absolute differences
    logic       d_valid_reg, d_oor_reg;
    logic [7:0] d_reg [0:5];

    function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid_reg <= 1'b0;
        else if (adv)
            d_valid_reg <= iss_done;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_oor_reg <= iss_oor_reg;
            for (int k = 0; k < 3; k++)
            begin
                d_reg[k]   <= absdiff(pix_reg[0][8*k +: 8], pix_reg[1][8*k +: 8]);
                d_reg[k+3] <= absdiff(pix_reg[2][8*k +: 8], ram_rdata[8*k +: 8]);
            end
        end
    end

    // stage: squares
    logic        q_valid_reg, q_oor_reg;
    logic [15:0] q_reg [0:5];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_valid_reg <= 1'b0;
        else if (adv)
            q_valid_reg <= d_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_oor_reg <= d_oor_reg;
            for (int k = 0; k < 6; k++)
                q_reg[k] <= 16'(d_reg[k]) * 16'(d_reg[k]);
        end
    end

    // stage: sum
    logic             s_valid_reg, s_oor_reg;
    logic [SUM_W-1:0] s_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_valid_reg <= 1'b0;
        else if (adv)
            s_valid_reg <= q_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_oor_reg <= q_oor_reg;
            s_reg <= SUM_W'(q_reg[0]) + SUM_W'(q_reg[1]) + SUM_W'(q_reg[2])
                   + SUM_W'(q_reg[3]) + SUM_W'(q_reg[4]) + SUM_W'(q_reg[5]);
        end
    end

    // stages: bitwise square root, two result bits per stage
    logic             rt_valid_reg [0:SQRT_STAGES-1];
    logic             rt_oor_reg   [0:SQRT_STAGES-1];
    logic [SUM_W-1:0] rt_v_reg     [0:SQRT_STAGES-1];
    logic [SUM_W-1:0] rt_r_reg     [0:SQRT_STAGES-1];

    function automatic logic [2*SUM_W-1:0] sqrt_steps(input logic [SUM_W-1:0] v_in,
                                                     input logic [SUM_W-1:0] r_in,
                                                     input int stage);
        logic [SUM_W-1:0] v, r, b;
        v = v_in;
        r = r_in;
        for (int i = 0; i < 2; i++)
        begin
            b = SUM_W'(1) << (18 - 2 * (2 * stage + i));
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
        end
        return {v, r};
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SQRT_STAGES; s++)
                rt_valid_reg[s] <= 1'b0;
        end
        else if (adv)
        begin
            rt_valid_reg[0] <= s_valid_reg;
            for (int s = 1; s < SQRT_STAGES; s++)
                rt_valid_reg[s] <= rt_valid_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rt_oor_reg[0] <= s_oor_reg;
            {rt_v_reg[0], rt_r_reg[0]} <= sqrt_steps(s_reg, '0, 0);
            for (int s = 1; s < SQRT_STAGES; s++)
            begin
                rt_oor_reg[s] <= rt_oor_reg[s-1];
                {rt_v_reg[s], rt_r_reg[s]} <= sqrt_steps(rt_v_reg[s-1], rt_r_reg[s-1], s);
            end
        end
    end

    // stage: divide by ten
    logic                           l_valid_reg;
    rsp_t                           l_reg;
    logic [ROOT_W+DIV10_SHIFT-1:0]  prod;

    assign prod = (ROOT_W+DIV10_SHIFT)'(rt_r_reg[SQRT_STAGES-1][ROOT_W-1:0])
                * (ROOT_W+DIV10_SHIFT)'(DIV10_MULT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            l_valid_reg <= 1'b0;
        else if (adv)
            l_valid_reg <= rt_valid_reg[SQRT_STAGES-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l_reg.out_of_range <= rt_oor_reg[SQRT_STAGES-1];
            l_reg.energy <= rt_oor_reg[SQRT_STAGES-1] ? 6'd0 : prod[DIV10_SHIFT +: 6];
        end
    end

    // output register with skid slot
    logic main_valid_reg, push, pop;
    rsp_t main_reg, skid_reg;

    assign push      = adv && l_valid_reg;
    assign pop       = main_valid_reg && rsp_ready;
    assign rsp_valid = main_valid_reg;
    assign rsp       = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop || !main_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                main_valid_reg <= push;
        end
        else if (push)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (pop || !main_valid_reg)
        begin
            if (skid_valid_reg)
                main_reg <= skid_reg;
            else if (push)
                main_reg <= l_reg;
        end
        else if (push)
            skid_reg <= l_reg;
    end

endmodule

[tb/tb_top.sv]
// Testbench for the dual-gradient energy block: random loads and queries checked against a predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import dge_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    req_t        req = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    rsp_t        rsp;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    localparam logic [2:0] ADDR_WIDTH  = 3'd0;
    localparam logic [2:0] ADDR_HEIGHT = 3'd4;

    dual_gradient_energy_top dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predictor state
    logic [23:0] frame_mirror [0:16383];
    bit          pix_loaded [0:16383];
    logic [7:0]  width_reg = 8'd128;
    logic [7:0]  height_reg = 8'd128;

    req_t pending_reqs [$];
    rsp_t expected_energy [$];
    int   error_count = 0;

    task automatic report(input string what, input rsp_t got, input rsp_t want);
        error_count++;
        $display("mismatch %s: got energy=%0d oor=%0d want energy=%0d oor=%0d",
                 what, got.energy, got.out_of_range, want.energy, want.out_of_range);
    endtask

    function automatic int eff(input logic [7:0] r);
        if (r == 0) return 1;
        if (r > 128) return 128;
        return r;
    endfunction

    function automatic int sq_diff(input logic [23:0] a, input logic [23:0] b);
        int s;
        int d;
        s = 0;
        for (int k = 0; k < 3; k++)
        begin
            d = int'(a[8*k +: 8]) - int'(b[8*k +: 8]);
            s += d * d;
        end
        return s;
    endfunction

    function automatic int root_floor(input int v);
        int x;
        x = 0;
        while ((x + 1) * (x + 1) <= v) x++;
        return x;
    endfunction

    function automatic logic [23:0] pix(input int r, input int c);
        return pix_loaded[r*128+c] ? frame_mirror[r*128+c] : 24'd0;
    endfunction

    // apply one accepted request to the mirror; queues a result for a query
    task automatic predict_energy(input req_t q);
        int w, h, r, c, sum;
        rsp_t e;
        w = eff(width_reg);
        h = eff(height_reg);
        r = q.row;
        c = q.col;
        if (q.opcode == OP_LOAD)
        begin
            if (r < h && c < w)
            begin
                frame_mirror[r*128+c] = {q.red, q.green, q.blue};
                pix_loaded[r*128+c] = 1'b1;
            end
        end
        else
        begin
            e = '0;
            if (r >= h || c >= w)
                e.out_of_range = 1'b1;
            else
            begin
                sum = sq_diff(pix(r, (c + 1) % w), pix(r, (c + w - 1) % w))
                    + sq_diff(pix((r + 1) % h, c), pix((r + h - 1) % h, c));
                e.energy = 6'(root_floor(sum) / 10);
            end
            expected_energy.push_back(e);
        end
    endtask

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // driver
    int send_gap = 0;
    int acc_cnt = 0;
    int issued = 0;

    always @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            predict_energy(req);
            acc_cnt++;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && acc_cnt != issued)
                ;
            else if (send_gap > 0)
            begin
                req_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_reqs.size() > 0)
            begin
                req_valid <= 1'b1;
                req <= pending_reqs.pop_front();
                issued <= issued + 1;
                send_gap <= gap_len();
            end
            else
                req_valid <= 1'b0;
        end
    end

    // monitor
    int rcv_gap = 0;
    always @(posedge clk)
    begin
        if (rsp_valid && rsp_ready)
        begin
            if (expected_energy.size() == 0)
                report("unexpected response", rsp, '0);
            else if (rsp !== expected_energy[0])
            begin
                report("response", rsp, expected_energy[0]);
                void'(expected_energy.pop_front());
            end
            else
                void'(expected_energy.pop_front());
        end
    end

    always @(negedge clk)
    begin
        if (rcv_gap > 0)
        begin
            rsp_ready <= 1'b0;
            rcv_gap <= rcv_gap - 1;
        end
        else
        begin
            rsp_ready <= 1'b1;
            rcv_gap <= ($urandom_range(0, 3) == 0) ? gap_len() : 0;
        end
    end

    task automatic apb_write(input logic [2:0] a, input logic [7:0] v);
        @(negedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= {24'd0, v};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (a == ADDR_WIDTH) width_reg = v; else height_reg = v;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // waits until every pending request is sent and every expected response has come
    task automatic drain();
        while (pending_reqs.size() > 0 || req_valid || expected_energy.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic req_t mk(input logic op, input int r, input int c);
        req_t q;
        q.opcode = op;
        q.row = 7'(r);
        q.col = 7'(c);
        q.red = 8'($urandom_range(0, 255));
        q.green = 8'($urandom_range(0, 255));
        q.blue = 8'($urandom_range(0, 255));
        return q;
    endfunction

    // fill the whole w x h frame, then mix reloads and queries inside it plus noise
    task automatic run_phase(input int w, input int h, input int n);
        int r, c, p;
        req_t q;
        apb_write(ADDR_WIDTH, 8'(w));
        apb_write(ADDR_HEIGHT, 8'(h));
        for (int i = 0; i < eff(8'(h)); i++)
            for (int j = 0; j < eff(8'(w)); j++)
                pending_reqs.push_back(mk(OP_LOAD, i, j));
        for (int k = 0; k < n; k++)
        begin
            p = $urandom_range(0, 99);
            r = $urandom_range(0, eff(8'(h)) - 1);
            c = $urandom_range(0, eff(8'(w)) - 1);
            if (p < 5)
            begin
                r = $urandom_range(0, 127);
                c = $urandom_range(0, 127);
            end
            q = mk((p % 3 == 0) ? OP_LOAD : OP_QUERY, r, c);
            pending_reqs.push_back(q);
        end
        drain();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // directed: tiny frame with wraps, extremes, out-of-frame loads and queries
        apb_write(ADDR_WIDTH, 8'd2);
        apb_write(ADDR_HEIGHT, 8'd1);
        pending_reqs.push_back(req_t'{OP_LOAD, 7'd0, 7'd0, 8'hFF, 8'hFF, 8'hFF});
        pending_reqs.push_back(req_t'{OP_LOAD, 7'd0, 7'd1, 8'h00, 8'h00, 8'h00});
        pending_reqs.push_back(req_t'{OP_LOAD, 7'd127, 7'd127, 8'hAA, 8'h55, 8'h0F});
        pending_reqs.push_back(req_t'{OP_QUERY, 7'd0, 7'd0, 8'hFF, 8'hFF, 8'hFF});
        pending_reqs.push_back(req_t'{OP_QUERY, 7'd0, 7'd1, 8'h00, 8'h00, 8'h00});
        pending_reqs.push_back(req_t'{OP_QUERY, 7'd1, 7'd0, 8'h00, 8'h00, 8'h00});
        pending_reqs.push_back(req_t'{OP_QUERY, 7'd127, 7'd127, 8'h00, 8'h00, 8'h00});
        drain();
        // zero registers act as one
        run_phase(0, 0, 6);
        // above maximum saturates; first load every neighbor of the two corner queries that is not yet loaded
        apb_write(ADDR_WIDTH, 8'd255);
        apb_write(ADDR_HEIGHT, 8'd200);
        pending_reqs.push_back(mk(OP_LOAD, 127, 0));
        pending_reqs.push_back(mk(OP_LOAD, 127, 126));
        pending_reqs.push_back(mk(OP_LOAD, 0, 127));
        pending_reqs.push_back(mk(OP_LOAD, 126, 127));
        pending_reqs.push_back(mk(OP_LOAD, 1, 0));
        pending_reqs.push_back(mk(OP_QUERY, 127, 127));
        pending_reqs.push_back(mk(OP_QUERY, 0, 0));
        drain();
        run_phase(3, 3, 20);
        run_phase(1, 9, 30);
        run_phase(12, 1, 30);
        run_phase(6, 5, 60);
        run_phase(6, 5, 0);
        run_phase(5, 7, 40);
        run_phase(128, 1, 20);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule

[dual_gradient_energy_top.f]
sv/dge_pkg.sv
sv/dge_ram.sv
sv/dual_gradient_energy_top.sv
tb/tb_top.sv
